// ===== rtl/sawc_pkg.sv =====
// Shared types, codes and default sizes of the set-associative write-back cache.
`default_nettype none
package sawc_pkg;

  localparam int DEF_NUM_SETS     = 16;
  localparam int DEF_NUM_WAYS     = 4;
  localparam int DEF_BLOCK_WORDS  = 16;
  localparam int DEF_ADDRESS_BITS = 32;

  // widest way index the meta command can carry (NUM_WAYS up to 16)
  localparam int WAY_MAX_W = 4;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FILL  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_WB    = 2'd1,
    KIND_FETCH = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_HIT_OUT,
    ST_WB_RD,
    ST_WB_OUT,
    ST_FETCH,
    ST_FILL_END,
    ST_FILL_RD
  } state_e;

  typedef struct packed {
    logic                 touch;      // hit: promote way to MRU
    logic                 set_dirty;  // write hit
    logic                 inval;      // victim dropped at miss
    logic                 fill;       // refill done: validate and promote
    logic                 fill_dirty;
    logic [WAY_MAX_W-1:0] way;
  } meta_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/sawc_if.sv =====
// Request and response channel interfaces of the cache.
`default_nettype none
interface sawc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] address;
  logic [31:0] data;

  modport source (output valid, mode, address, data, input ready);
  modport sink   (input valid, mode, address, data, output ready);
endinterface

interface sawc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] out_address;
  logic [31:0] out_data;
  logic        was_hit;
  logic        last;
  logic [31:0] read_accesses;
  logic [31:0] read_misses;
  logic [31:0] write_accesses;
  logic [31:0] write_misses;

  modport source (output valid, kind, out_address, out_data, was_hit, last,
                  read_accesses, read_misses, write_accesses, write_misses,
                  input ready);
  modport sink   (input valid, kind, out_address, out_data, was_hit, last,
                  read_accesses, read_misses, write_accesses, write_misses,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/sawc_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module sawc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    // hold read data between reads
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/sawc_meta.sv =====
// Per-line valid, dirty and LRU rank state with victim selection.
`default_nettype none
module sawc_meta #(
  parameter int NUM_SETS = 16,
  parameter int NUM_WAYS = 4,
  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
  localparam int WAY_W = $clog2(NUM_WAYS)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [SET_W-1:0]       set_i,
  input  wire sawc_pkg::meta_cmd_t    cmd_i,
  output logic      [NUM_WAYS-1:0]    valid_o,
  output logic      [NUM_WAYS-1:0]    dirty_o,
  output logic      [WAY_W-1:0]       victim_o
);
  import sawc_pkg::*;

  localparam int LINES  = NUM_SETS * NUM_WAYS;
  localparam int LINE_W = $clog2(LINES);
  localparam int RW     = $clog2(NUM_WAYS);
  localparam logic [RW-1:0] MAX_RANK = RW'(NUM_WAYS - 1);

  logic [LINES-1:0] valid_q;
  logic [LINES-1:0] dirty_q;
  logic [RW-1:0]    rank_q [LINES];

  logic [RW-1:0]    rank_w [NUM_WAYS];
  logic [WAY_W-1:0] way;
  logic [RW-1:0]    mine;

  function automatic logic [LINE_W-1:0] line_of(input logic [SET_W-1:0] s, input int w);
    return LINE_W'(32'(s) * NUM_WAYS + w);
  endfunction

  assign way  = WAY_W'(cmd_i.way);
  assign mine = rank_w[way];

  always_comb begin
    for (int j = 0; j < NUM_WAYS; j++) begin
      valid_o[j] = valid_q[line_of(set_i, j)];
      dirty_o[j] = dirty_q[line_of(set_i, j)];
      rank_w[j]  = rank_q[line_of(set_i, j)];
    end
  end

  // first invalid way, else first way of largest rank
  always_comb begin
    logic found;
    found    = 1'b0;
    victim_o = '0;
    for (int j = 1; j < NUM_WAYS; j++) begin
      if (rank_w[j] > rank_w[victim_o]) begin
        victim_o = WAY_W'(j);
      end
    end
    for (int j = 0; j < NUM_WAYS; j++) begin
      if (!found && !valid_o[j]) begin
        found    = 1'b1;
        victim_o = WAY_W'(j);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int l = 0; l < LINES; l++) begin
        rank_q[l] <= '0;
      end
    end else begin
      if (cmd_i.inval) begin
        valid_q[line_of(set_i, int'(way))] <= 1'b0;
        dirty_q[line_of(set_i, int'(way))] <= 1'b0;
        rank_q[line_of(set_i, int'(way))]  <= '0;
      end
      if (cmd_i.set_dirty) begin
        dirty_q[line_of(set_i, int'(way))] <= 1'b1;
      end
      if (cmd_i.touch || cmd_i.fill) begin
        for (int j = 0; j < NUM_WAYS; j++) begin
          if (WAY_W'(j) == way) begin
            rank_q[line_of(set_i, j)] <= '0;
          end else if (valid_o[j] && (cmd_i.fill || rank_w[j] < mine)
                       && rank_w[j] < MAX_RANK) begin
            rank_q[line_of(set_i, j)] <= rank_w[j] + 1'b1;
          end
        end
      end
      if (cmd_i.fill) begin
        valid_q[line_of(set_i, int'(way))] <= 1'b1;
        dirty_q[line_of(set_i, int'(way))] <= cmd_i.fill_dirty;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/set_assoc_writeback_cache.sv =====
// Top level: set-associative write-back, write-allocate cache controller.
// Hit: tag RAM read, data RAM access, result register.
// Miss: tag lookup, then a data read and a result per written-back word of a dirty victim, then the fetch request.
// Fill: one word per cycle; after the last word the result is loaded in FILL_END (write miss) or FILL_RD (read miss).
// One item at a time; the single-port tag and data RAMs set the pace.
// Reset clears valid, dirty, ranks, counters and pending miss; RAM contents stay.
`default_nettype none
module set_assoc_writeback_cache #(
  parameter int NUM_SETS     = sawc_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS     = sawc_pkg::DEF_NUM_WAYS,
  parameter int BLOCK_WORDS  = sawc_pkg::DEF_BLOCK_WORDS,
  parameter int ADDRESS_BITS = sawc_pkg::DEF_ADDRESS_BITS
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sawc_in_if.sink     req_i,
  sawc_out_if.source  rsp_o
);
  import sawc_pkg::*;

  localparam int OFF_W   = $clog2(BLOCK_WORDS);
  localparam int SET_B   = $clog2(NUM_SETS);
  localparam int SET_W   = (SET_B > 0) ? SET_B : 1;
  localparam int WORD_W  = (OFF_W > 0) ? OFF_W : 1;
  localparam int WAY_W   = $clog2(NUM_WAYS);
  localparam int TAG_W   = ADDRESS_BITS - 2 - OFF_W - SET_B;
  localparam int ROW_W   = NUM_WAYS * TAG_W;
  localparam int LINES   = NUM_SETS * NUM_WAYS;
  localparam int DDEPTH  = LINES * BLOCK_WORDS;
  localparam int DADDR_W = $clog2(DDEPTH);
  localparam logic [31:0] AMASK = (ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF
                                  : 32'((64'd1 << ADDRESS_BITS) - 64'd1);
  localparam logic [31:0] BLK_MASK = 32'(4 * BLOCK_WORDS - 1);
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(BLOCK_WORDS - 1);

  function automatic logic [SET_W-1:0] set_of(input logic [31:0] a);
    return SET_W'((a >> (2 + OFF_W)) & 32'(NUM_SETS - 1));
  endfunction
  function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
    return TAG_W'(64'(a) >> (2 + OFF_W + SET_B));
  endfunction
  function automatic logic [WORD_W-1:0] word_of(input logic [31:0] a);
    return WORD_W'((a >> 2) & 32'(BLOCK_WORDS - 1));
  endfunction
  function automatic logic [DADDR_W-1:0] daddr(input logic [SET_W-1:0] s,
      input logic [WAY_W-1:0] w, input logic [WORD_W-1:0] i);
    return DADDR_W'((32'(s) * NUM_WAYS + 32'(w)) * BLOCK_WORDS + 32'(i));
  endfunction

  state_e state_q, state_d;

  logic              busy_q, wr_q, hit_q;
  logic [31:0]       addr_q, data_q;
  logic [WAY_W-1:0]  way_q;
  logic [WORD_W-1:0] idx_q;
  logic [ROW_W-1:0]  row_q;
  logic [TAG_W-1:0]  victag_q;
  logic [31:0]       cnt_q [4];

  // result register
  logic        out_vq;
  kind_e       kind_q;
  logic [31:0] oaddr_q, odata_q;
  logic        ohit_q, olast_q;
  logic [31:0] ocnt_q [4];

  logic              acc, out_free, in_access, in_fill;
  logic [31:0]       in_addr;
  logic [SET_W-1:0]  set_q;
  logic              t_re, t_we, d_re, d_we;
  logic [SET_W-1:0]  t_addr;
  logic [ROW_W-1:0]  t_rdata, new_row;
  logic [DADDR_W-1:0] d_addr;
  logic [31:0]       d_wdata, d_rdata;
  meta_cmd_t         mcmd;
  logic [NUM_WAYS-1:0] m_valid, m_dirty;
  logic [WAY_W-1:0]  victim;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic [TAG_W-1:0]  vic_tag;
  logic              out_ld, o_hit, o_last;
  kind_e             o_kind;
  logic [31:0]       o_addr, o_data, wb_addr;

  assign in_addr   = req_i.address & AMASK & ~32'd3;
  assign acc       = req_i.valid && req_i.ready;
  assign in_access = (req_i.mode == MODE_READ) || (req_i.mode == MODE_WRITE);
  assign in_fill   = (req_i.mode == MODE_FILL);
  assign out_free  = !out_vq || rsp_o.ready;
  assign set_q     = set_of(addr_q);
  assign req_i.ready = (state_q == ST_IDLE);

  sawc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
    .clk_i, .we_i(t_we), .re_i(t_re), .addr_i(t_addr), .wdata_i(new_row),
    .rdata_o(t_rdata)
  );

  sawc_ram #(.WIDTH(32), .DEPTH(DDEPTH)) u_data_ram (
    .clk_i, .we_i(d_we), .re_i(d_re), .addr_i(d_addr), .wdata_i(d_wdata),
    .rdata_o(d_rdata)
  );

  sawc_meta #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_meta (
    .clk_i, .rst_ni, .set_i(set_q), .cmd_i(mcmd),
    .valid_o(m_valid), .dirty_o(m_dirty), .victim_o(victim)
  );

  // tag compare and victim tag
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    vic_tag = '0;
    for (int j = NUM_WAYS - 1; j >= 0; j--) begin
      if (m_valid[j] && t_rdata[j*TAG_W +: TAG_W] == tag_of(addr_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(j);
      end
      if (WAY_W'(j) == victim) begin
        vic_tag = t_rdata[j*TAG_W +: TAG_W];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_WAYS; j++) begin
      new_row[j*TAG_W +: TAG_W] = (WAY_W'(j) == way_q) ? tag_of(addr_q)
                                                       : row_q[j*TAG_W +: TAG_W];
    end
  end

  assign wb_addr = 32'((64'(victag_q) << (2 + OFF_W + SET_B))
                     | (64'(set_q) << (2 + OFF_W)) | (64'(idx_q) << 2));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && in_access && !busy_q) begin
          state_d = ST_LOOKUP;
        end else if (acc && in_fill && busy_q && idx_q == LAST_WORD) begin
          state_d = ST_FILL_END;
        end
      end
      ST_LOOKUP: begin
        if (hit) begin
          state_d = ST_HIT_OUT;
        end else if (m_valid[victim] && m_dirty[victim]) begin
          state_d = ST_WB_RD;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_HIT_OUT:  if (out_free) state_d = ST_IDLE;
      ST_WB_RD:    state_d = ST_WB_OUT;
      ST_WB_OUT: begin
        if (out_free) state_d = (idx_q == LAST_WORD) ? ST_FETCH : ST_WB_RD;
      end
      ST_FETCH:    if (out_free) state_d = ST_IDLE;
      ST_FILL_END: begin
        if (!wr_q) begin
          state_d = ST_FILL_RD;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_FILL_RD:  if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // memory, meta and result controls
  always_comb begin
    t_re    = 1'b0;
    t_we    = 1'b0;
    t_addr  = set_q;
    d_re    = 1'b0;
    d_we    = 1'b0;
    d_addr  = daddr(set_q, way_q, word_of(addr_q));
    d_wdata = data_q;
    mcmd    = '0;
    mcmd.way = WAY_MAX_W'(way_q);
    out_ld  = 1'b0;
    o_kind  = KIND_DONE;
    o_addr  = addr_q;
    o_data  = '0;
    o_hit   = 1'b0;
    o_last  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (acc && in_access && !busy_q) begin
          t_re   = 1'b1;
          t_addr = set_of(in_addr);
        end else if (acc && in_fill && busy_q) begin
          d_we    = 1'b1;
          d_addr  = daddr(set_q, way_q, idx_q);
          d_wdata = req_i.data;
        end
      end
      ST_LOOKUP: begin
        if (hit) begin
          mcmd.touch = 1'b1;
          mcmd.way   = WAY_MAX_W'(hit_way);
          d_addr     = daddr(set_q, hit_way, word_of(addr_q));
          if (wr_q) begin
            d_we           = 1'b1;
            mcmd.set_dirty = 1'b1;
          end else begin
            d_re = 1'b1;
          end
        end else begin
          mcmd.inval = 1'b1;
          mcmd.way   = WAY_MAX_W'(victim);
        end
      end
      ST_HIT_OUT: begin
        out_ld = out_free;
        o_data = wr_q ? '0 : d_rdata;
        o_hit  = 1'b1;
      end
      ST_WB_RD: begin
        d_re   = 1'b1;
        d_addr = daddr(set_q, way_q, idx_q);
      end
      ST_WB_OUT: begin
        out_ld = out_free;
        o_kind = KIND_WB;
        o_addr = wb_addr;
        o_data = d_rdata;
        o_last = 1'b0;
      end
      ST_FETCH: begin
        out_ld = out_free;
        o_kind = KIND_FETCH;
        o_addr = addr_q & ~BLK_MASK;
      end
      ST_FILL_END: begin
        if (!wr_q) begin
          d_re = 1'b1;
        end else if (out_free) begin
          d_we            = 1'b1;
          t_we            = 1'b1;
          mcmd.fill       = 1'b1;
          mcmd.fill_dirty = 1'b1;
          out_ld          = 1'b1;
        end
      end
      ST_FILL_RD: begin
        if (out_free) begin
          t_we      = 1'b1;
          mcmd.fill = 1'b1;
          out_ld    = 1'b1;
          o_data    = d_rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      idx_q   <= '0;
      out_vq  <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_ld) begin
        out_vq <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vq <= 1'b0;
      end
      if (state_q == ST_IDLE && acc && in_fill && busy_q) begin
        idx_q <= (idx_q == LAST_WORD) ? '0 : idx_q + 1'b1;
      end
      if (state_q == ST_LOOKUP) begin
        cnt_q[wr_q ? 2 : 0] <= cnt_q[wr_q ? 2 : 0] + 32'd1;
        if (!hit) begin
          cnt_q[wr_q ? 3 : 1] <= cnt_q[wr_q ? 3 : 1] + 32'd1;
          busy_q <= 1'b1;
          idx_q  <= '0;
        end
      end
      if (state_q == ST_WB_OUT && out_free) begin
        idx_q <= (idx_q == LAST_WORD) ? '0 : idx_q + 1'b1;
      end
      if ((state_q == ST_FILL_END || state_q == ST_FILL_RD) && t_we) begin
        busy_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && acc && in_access && !busy_q) begin
      addr_q <= in_addr;
      wr_q   <= (req_i.mode == MODE_WRITE);
      data_q <= req_i.data;
    end
    if (state_q == ST_LOOKUP) begin
      row_q    <= t_rdata;
      hit_q    <= hit;
      way_q    <= hit ? hit_way : victim;
      victag_q <= vic_tag;
    end
    if (out_ld) begin
      kind_q  <= o_kind;
      oaddr_q <= o_addr;
      odata_q <= o_data;
      ohit_q  <= o_hit;
      olast_q <= o_last;
      for (int k = 0; k < 4; k++) begin
        ocnt_q[k] <= (state_q == ST_LOOKUP) ? '0 : cnt_q[k];
      end
    end
  end

  assign rsp_o.valid          = out_vq;
  assign rsp_o.kind           = kind_q;
  assign rsp_o.out_address    = oaddr_q;
  assign rsp_o.out_data       = odata_q;
  assign rsp_o.was_hit        = ohit_q;
  assign rsp_o.last           = olast_q;
  assign rsp_o.read_accesses  = ocnt_q[0];
  assign rsp_o.read_misses    = ocnt_q[1];
  assign rsp_o.write_accesses = ocnt_q[2];
  assign rsp_o.write_misses   = ocnt_q[3];

  a_busy_ends_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> (rsp_o.valid && rsp_o.kind == KIND_DONE && rsp_o.last))
    else $error("pending miss cleared without a completion result");

  a_idx_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (idx_q == '0))
    else $error("word index not cleared outside a pending miss");

  a_hit_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.was_hit) |-> (rsp_o.kind == KIND_DONE))
    else $error("hit flag on a result other than a completed access");

  a_hit_state_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HIT_OUT) |-> hit_q)
    else $error("hit result path entered after a miss");
endmodule
`default_nettype wire

// ===== tb/sv/sawc_checker.sv =====
// Checker: watches the request and response channels, predicts the cache and compares.
module sawc_checker #(
  parameter int NUM_SETS    = 16,
  parameter int NUM_WAYS    = 4,
  parameter int BLOCK_WORDS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sawc_in_if.sink   req_i,
  sawc_out_if.sink  rsp_o,
  output int        fail_count,
  output int        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import sawc_pkg::*;

  localparam int LINES = NUM_SETS * NUM_WAYS;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic        hit;
    logic        last;
    logic [31:0] rd_acc;
    logic [31:0] rd_miss;
    logic [31:0] wr_acc;
    logic [31:0] wr_miss;
  } cache_rsp_t;

  cache_rsp_t  rsp_queue[$];
  logic [31:0] tags[LINES];
  logic        valid_q[LINES];
  logic        dirty_q[LINES];
  int          rank_q[LINES];
  logic [31:0] words[LINES*BLOCK_WORDS];
  logic        busy;
  logic        busy_write;
  logic [31:0] busy_addr;
  logic [31:0] busy_word;
  int          busy_way;
  int          fill_cnt;
  logic [31:0] cnt[4];

  assign pending_count = rsp_queue.size();

  function automatic int set_idx(logic [31:0] a);
    return (a / (4 * BLOCK_WORDS)) % NUM_SETS;
  endfunction

  function automatic logic [31:0] tag_val(logic [31:0] a);
    return a / (4 * BLOCK_WORDS * NUM_SETS);
  endfunction

  function automatic void push_rsp(kind_e k, logic [31:0] a, logic [31:0] d,
                                   logic h, logic l);
    cache_rsp_t r;
    r = '{k, a, d, h, l, cnt[0], cnt[1], cnt[2], cnt[3]};
    rsp_queue.push_back(r);
  endfunction

  function automatic void promote(int s, int way, logic hit);
    int base;
    int mine;
    base = s * NUM_WAYS;
    mine = rank_q[base+way];
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (i != way && valid_q[base+i])
        if ((!hit || rank_q[base+i] < mine) && rank_q[base+i] < NUM_WAYS-1)
          rank_q[base+i]++;
    end
    rank_q[base+way] = 0;
  endfunction

  function automatic void predict_access(logic [1:0] m, logic [31:0] a_in,
                                         logic [31:0] d);
    logic [31:0] a;
    int s, w, base, line, way;
    logic wr;
    logic [31:0] tg, start;
    a = a_in & ~32'd3;
    if (m == MODE_FILL) begin
      if (!busy) return;
      s = set_idx(busy_addr);
      line = s * NUM_WAYS + busy_way;
      words[line*BLOCK_WORDS + fill_cnt] = d;
      fill_cnt++;
      if (fill_cnt < BLOCK_WORDS) return;
      w = (busy_addr >> 2) % BLOCK_WORDS;
      if (busy_write) words[line*BLOCK_WORDS + w] = busy_word;
      tags[line] = tag_val(busy_addr);
      valid_q[line] = 1;
      dirty_q[line] = busy_write;
      promote(s, busy_way, 0);
      busy = 0;
      fill_cnt = 0;
      push_rsp(KIND_DONE, busy_addr, busy_write ? 32'd0 : words[line*BLOCK_WORDS + w], 0, 1);
      return;
    end
    if (m > MODE_WRITE || busy) return;
    wr = (m == MODE_WRITE);
    s = set_idx(a);
    w = (a >> 2) % BLOCK_WORDS;
    tg = tag_val(a);
    base = s * NUM_WAYS;
    cnt[wr ? 2 : 0]++;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (valid_q[base+i] && tags[base+i] == tg) begin
        if (wr) begin
          words[(base+i)*BLOCK_WORDS + w] = d;
          dirty_q[base+i] = 1;
        end
        promote(s, i, 1);
        push_rsp(KIND_DONE, a, wr ? 32'd0 : words[(base+i)*BLOCK_WORDS + w], 1, 1);
        return;
      end
    end
    cnt[wr ? 3 : 1]++;
    way = -1;
    for (int i = 0; i < NUM_WAYS; i++)
      if (way < 0 && !valid_q[base+i]) way = i;
    if (way < 0) begin
      way = 0;
      for (int i = 1; i < NUM_WAYS; i++)
        if (rank_q[base+i] > rank_q[base+way]) way = i;
    end
    line = base + way;
    if (valid_q[line] && dirty_q[line]) begin
      start = (tags[line] * NUM_SETS + s) * 4 * BLOCK_WORDS;
      for (int i = 0; i < BLOCK_WORDS; i++)
        push_rsp(KIND_WB, start + 4*i, words[line*BLOCK_WORDS + i], 0, 0);
    end
    valid_q[line] = 0;
    dirty_q[line] = 0;
    rank_q[line] = 0;
    busy = 1;
    busy_write = wr;
    busy_addr = a;
    busy_word = wr ? d : 32'd0;
    busy_way = way;
    fill_cnt = 0;
    push_rsp(KIND_FETCH, (tg * NUM_SETS + s) * 4 * BLOCK_WORDS, 0, 0, 1);
  endfunction

  initial begin
    fail_count = 0;
    busy = 0;
    busy_write = 0;
    busy_addr = 0;
    busy_word = 0;
    busy_way = 0;
    fill_cnt = 0;
    for (int i = 0; i < 4; i++) cnt[i] = 0;
    for (int i = 0; i < LINES; i++) begin
      valid_q[i] = 0;
      dirty_q[i] = 0;
      rank_q[i] = 0;
      tags[i] = 0;
    end
  end

  always @(posedge clk_i) begin
    cache_rsp_t got, exp_rsp;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready)
        predict_access(req_i.mode, req_i.address, req_i.data);
      if (rsp_o.valid && rsp_o.ready) begin
        got = '{kind_e'(rsp_o.kind), rsp_o.out_address, rsp_o.out_data, rsp_o.was_hit,
                rsp_o.last, rsp_o.read_accesses, rsp_o.read_misses,
                rsp_o.write_accesses, rsp_o.write_misses};
        if (rsp_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected response: %p", got);
        end else begin
          exp_rsp = rsp_queue.pop_front();
          if (got !== exp_rsp) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p actual %p", exp_rsp, got);
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/set_assoc_writeback_cache_tb.sv =====
// Testbench top: drives read, write, fill and unused-mode transfers into the cache and gives the verdict.
module set_assoc_writeback_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sawc_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   src_idle;
  int   snk_idle;
  int   sent;
  logic [31:0] hot[8];

  sawc_in_if  req_if();
  sawc_out_if rsp_if();

  set_assoc_writeback_cache i_dut (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if),
                                   .rsp_o(rsp_if));
  sawc_checker i_chk (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if), .rsp_o(rsp_if),
                      .fail_count(fail_count), .pending_count(pending_count));

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver stall
  always @(negedge clk_i)
    rsp_if.ready <= ($urandom_range(99) >= snk_idle);

  task automatic send(logic [1:0] m, logic [31:0] a, logic [31:0] d);
    while ($urandom_range(99) < src_idle) @(negedge clk_i);
    req_if.valid   <= 1;
    req_if.mode    <= m;
    req_if.address <= a;
    req_if.data    <= d;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    // drop valid at once so a following transfer can raise it in the same step
    req_if.valid = 0;
    sent++;
  endtask

  task automatic refill(int n);
    for (int i = 0; i < n; i++) send(MODE_FILL, $urandom, $urandom);
  endtask

  // full access: the miss is followed by a complete block refill
  task automatic access(logic [1:0] m, logic [31:0] a, logic [31:0] d);
    send(m, a, d);
    refill(16);
  endtask

  task automatic random_item();
    int r;
    logic [31:0] a;
    r = $urandom_range(99);
    a = ($urandom_range(3) == 0) ? $urandom : hot[$urandom_range(7)] | ($urandom_range(15) << 2)
        | ($urandom_range(3) << 6);
    if (r < 85) begin
      send(logic'($urandom_range(1)), a, $urandom);
      if (pending_count == 0) repeat (4) @(negedge clk_i);
      if ($urandom_range(9) == 0) refill($urandom_range(15)); else refill(16);
    end else if (r < 95) send(MODE_FILL, $urandom, $urandom);
    else send(2'd3, $urandom, $urandom);
  endtask

  task automatic run_phase(int si, int ki, int n);
    src_idle = si;
    snk_idle = ki;
    for (int i = 0; i < n; i++) random_item();
  endtask

  initial begin
    int waited;
    sent = 0;
    src_idle = 0;
    snk_idle = 0;
    rst_ni = 0;
    req_if.valid = 0;
    req_if.mode = MODE_READ;
    req_if.address = 0;
    req_if.data = 0;
    rsp_if.ready = 0;
    for (int i = 0; i < 8; i++) hot[i] = $urandom & 32'hffff_fc00;
    hot[0] = 0;
    hot[1] = 32'hffff_fc00;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    src_idle = 25;
    snk_idle = 55;
    // directed: fill while idle, unused mode, extremes, hits, a dirty eviction
    send(MODE_FILL, 0, 32'hffff_ffff);
    send(2'd3, 32'hffff_ffff, 0);
    access(MODE_READ, 32'h0, 0);
    send(MODE_READ, 32'h3c, 0);
    send(MODE_WRITE, 32'h7, 32'hffff_ffff);
    access(MODE_WRITE, 32'hffff_ffff, 32'h5a5a_a5a5);
    send(MODE_READ, 32'hffff_fffc, 0);
    send(MODE_READ, 32'h4, 0);
    send(MODE_READ, 32'h4, 0);   // repeated read hit
    refill(16);
    for (int t = 1; t <= 4; t++)
      access(MODE_WRITE, t << 10, t);  // fill set 0 then evict a dirty line
    send(MODE_READ, 32'h400, 0);
    run_phase(25, 55, 7);
    run_phase(55, 25, 7);
    run_phase(0, 0, 7);
    waited = 0;
    while (pending_count != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
